FILE: design/epoch_seconds_to_calendar_defines.svh
// assertion macros for the epoch seconds to calendar converter
// used by the checker module, no other dependencies
`ifndef EPOCH_SECONDS_TO_CALENDAR_DEFINES_SVH
`define EPOCH_SECONDS_TO_CALENDAR_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define E2C_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define E2C_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/e2c_pkg.sv
// shared widths, constants, types and the month table of the converter
// no dependencies
package e2c_pkg;

  localparam int unsigned NumStages = 8;

  localparam int unsigned SecsW  = 32;
  localparam int unsigned DaysW  = 16;
  localparam int unsigned TodW   = 17;
  localparam int unsigned YearW  = 12;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DomW   = 5;
  localparam int unsigned HourW  = 5;
  localparam int unsigned MinW   = 6;
  localparam int unsigned SecW   = 6;
  localparam int unsigned MsW    = 12;
  localparam int unsigned BlockW = 6;
  localparam int unsigned OffW   = 11;
  localparam int unsigned YibW   = 2;
  localparam int unsigned DoyW   = 9;
  localparam int unsigned MpW    = 4;

  // seconds to days: secs >> 7 divided by 675 via reciprocal, then one correction
  localparam int unsigned DayPreShift = 7;
  localparam int unsigned DayRecipW   = 26;
  localparam logic [DayRecipW-1:0] DayRecip = 26'd50903316;
  localparam int unsigned DayShift    = 35;
  localparam logic [TodW-1:0] SecsPerDay = 17'd86400;

  // exact reciprocals for the time of day
  localparam logic [15:0] HourRecip = 16'd37283;
  localparam int unsigned HourShift = 27;
  localparam logic [MsW-1:0] SecsPerHour = 12'd3600;
  localparam logic [12:0] MinRecip = 13'd4370;
  localparam int unsigned MinShift = 18;
  localparam logic [SecW-1:0] SecsPerMin = 6'd60;

  // day count from 1968-03-01, four-year blocks of 1461 days
  localparam logic [DaysW-1:0] EpochOffset = 16'd671;
  // 2100-03-01: no leap day in 2100, so later days shift up by one
  localparam logic [DaysW-1:0] CenturySkip = 16'd48212;
  localparam logic [15:0] BlockRecip = 16'd45934;
  localparam int unsigned BlockShift = 26;
  localparam logic [OffW-1:0] DaysPerBlock = 11'd1461;
  localparam logic [OffW-1:0] Year1Start = 11'd365;
  localparam logic [OffW-1:0] Year2Start = 11'd730;
  localparam logic [OffW-1:0] Year3Start = 11'd1095;
  localparam logic [YearW-1:0] YearBase = 12'd1968;
  localparam logic [MpW-1:0] MpJanuary = 4'd10;
  localparam int unsigned MonthsPerYear = 12;

  typedef struct packed {
    logic [HourW-1:0] hour;
    logic [MinW-1:0]  minute;
    logic [SecW-1:0]  second;
  } e2c_hms_t;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DomW-1:0]   day;
  } e2c_date_t;

  // first day of each month in a year starting at march 1
  function automatic logic [DoyW-1:0] month_start(input logic [MpW-1:0] mp);
    logic [DoyW-1:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

FILE: design/e2c_if.sv
// valid/ready channel interfaces for the timestamp input and the calendar output
// depends on e2c_pkg
interface e2c_in_if import e2c_pkg::*;;
  logic             valid;
  logic             ready;
  logic [SecsW-1:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink (input valid, input epoch_seconds, output ready);
endinterface

interface e2c_out_if import e2c_pkg::*;;
  logic              valid;
  logic              ready;
  logic [YearW-1:0]  year;
  logic [MonthW-1:0] month;
  logic [DomW-1:0]   day_of_month;
  logic [HourW-1:0]  hour;
  logic [MinW-1:0]   minute;
  logic [SecW-1:0]   second_of_minute;

  modport source (output valid, output year, output month, output day_of_month,
                  output hour, output minute, output second_of_minute, input ready);
  modport sink (input valid, input year, input month, input day_of_month,
                input hour, input minute, input second_of_minute, output ready);
endinterface

FILE: design/epoch_seconds_to_calendar.sv
// Epoch seconds to UTC calendar converter. Accepts one 32-bit timestamp per
// cycle when the output is not stalled and returns year, month, day of month,
// hour, minute and second from its last pipeline register. Every input
// value is valid; the leap rule is exact over the whole range, including
// 2100. Latency is set by the chain of constant-reciprocal multiplies, each
// followed by a register, that takes seconds to days, days to four-year blocks,
// and time of day to hours and minutes. A stalled output holds the pipeline
// without dropping or repeating anything, and bubbles close up on the way.
// Depends on e2c_pkg, the channel interfaces and the e2c_* stage modules.
module epoch_seconds_to_calendar import e2c_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  e2c_in_if.sink    in_i,
  e2c_out_if.source out_o
);

  logic [NumStages-1:0] vld_q, vld_d, en;
  logic [DaysW-1:0]     days;
  logic [TodW-1:0]      tod;
  e2c_hms_t             hms, hms_q;
  e2c_date_t            date, date_q;

  // a stage loads when empty or when the stage after it moves
  always_comb begin
    en[NumStages-1] = !vld_q[NumStages-1] || out_o.ready;
    for (int i = NumStages-2; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
    vld_d = {vld_q[NumStages-2:0], in_i.valid};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int i = 0; i < NumStages; i++) begin
        if (en[i]) begin
          vld_q[i] <= vld_d[i];
        end
      end
    end
  end

  assign in_i.ready = en[0];

  e2c_day_div u_day_div (
    .clk_i  (clk_i),
    .en_i   (en[1:0]),
    .secs_i (in_i.epoch_seconds),
    .days_o (days),
    .tod_o  (tod)
  );

  e2c_tod_split u_tod_split (
    .clk_i (clk_i),
    .en_i  (en[6:2]),
    .tod_i (tod),
    .hms_o (hms)
  );

  e2c_date_calc u_date_calc (
    .clk_i  (clk_i),
    .en_i   (en[6:2]),
    .days_i (days),
    .date_o (date)
  );

  always_ff @(posedge clk_i) begin
    if (en[NumStages-1]) begin
      hms_q  <= hms;
      date_q <= date;
    end
  end

  assign out_o.valid            = vld_q[NumStages-1];
  assign out_o.year             = date_q.year;
  assign out_o.month            = date_q.month;
  assign out_o.day_of_month     = date_q.day;
  assign out_o.hour             = hms_q.hour;
  assign out_o.minute           = hms_q.minute;
  assign out_o.second_of_minute = hms_q.second;

endmodule

FILE: design/e2c_day_div.sv
// two pipeline stages: seconds split into whole days and time of day
// depends on e2c_pkg
module e2c_day_div import e2c_pkg::*; (
  input  logic             clk_i,
  input  logic [1:0]       en_i,
  input  logic [SecsW-1:0] secs_i,
  output logic [DaysW-1:0] days_o,
  output logic [TodW-1:0]  tod_o
);

  localparam int unsigned PreW  = SecsW - DayPreShift;
  localparam int unsigned ProdW = PreW + DayRecipW;

  logic [ProdW-1:0]       est_prod;
  logic [DaysW-1:0]       est_d, est_q;
  logic [SecsW-1:0]       secs_q;
  logic [DaysW+TodW-1:0]  fix_prod;
  logic [SecsW:0]         rem;
  logic [TodW:0]          rem_lo;
  logic                   over;
  logic [DaysW-1:0]       days_d, days_q;
  logic [TodW-1:0]        tod_d, tod_q;

  // estimate is the true quotient or one less
  assign est_prod = ProdW'(secs_i[SecsW-1:DayPreShift]) * ProdW'(DayRecip);
  assign est_d    = est_prod[DayShift +: DaysW];

  assign fix_prod = (DaysW+TodW)'(est_q) * (DaysW+TodW)'(SecsPerDay);
  assign rem      = {1'b0, secs_q} - (SecsW+1)'(fix_prod);
  assign rem_lo   = rem[TodW:0];
  assign over     = rem_lo >= {1'b0, SecsPerDay};
  assign days_d   = est_q + DaysW'(over);
  assign tod_d    = over ? TodW'(rem_lo - {1'b0, SecsPerDay}) : rem_lo[TodW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      est_q  <= est_d;
      secs_q <= secs_i;
    end
    if (en_i[1]) begin
      days_q <= days_d;
      tod_q  <= tod_d;
    end
  end

  assign days_o = days_q;
  assign tod_o  = tod_q;

endmodule

FILE: design/e2c_tod_split.sv
// five pipeline stages: time of day into hour, minute and second
// depends on e2c_pkg
module e2c_tod_split import e2c_pkg::*; (
  input  logic            clk_i,
  input  logic [4:0]      en_i,
  input  logic [TodW-1:0] tod_i,
  output e2c_hms_t        hms_o
);

  localparam int unsigned HourProdW = TodW + 16;
  localparam int unsigned MinProdW  = MsW + 13;

  logic [HourProdW-1:0] hour_prod;
  logic [HourW-1:0]     hour3_q, hour4_q, hour5_q, hour6_q;
  logic [TodW-1:0]      tod3_q;
  logic [TodW-1:0]      hour_secs;
  logic [MsW-1:0]       ms_d, ms4_q, ms5_q;
  logic [MinProdW-1:0]  min_prod;
  logic [MinW-1:0]      min5_q, min6_q;
  logic [MsW-1:0]       min_secs;
  logic [SecW-1:0]      sec_d, sec6_q;
  e2c_hms_t             hms_q;

  assign hour_prod = HourProdW'(tod_i) * HourProdW'(HourRecip);
  assign hour_secs = TodW'(hour3_q) * TodW'(SecsPerHour);
  assign ms_d      = MsW'(tod3_q - hour_secs);
  assign min_prod  = MinProdW'(ms4_q) * MinProdW'(MinRecip);
  assign min_secs  = MsW'(min5_q) * MsW'(SecsPerMin);
  assign sec_d     = SecW'(ms5_q - min_secs);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      hour3_q <= hour_prod[HourShift +: HourW];
      tod3_q  <= tod_i;
    end
    if (en_i[1]) begin
      hour4_q <= hour3_q;
      ms4_q   <= ms_d;
    end
    if (en_i[2]) begin
      hour5_q <= hour4_q;
      ms5_q   <= ms4_q;
      min5_q  <= min_prod[MinShift +: MinW];
    end
    if (en_i[3]) begin
      hour6_q <= hour5_q;
      min6_q  <= min5_q;
      sec6_q  <= sec_d;
    end
    if (en_i[4]) begin
      hms_q <= '{hour: hour6_q, minute: min6_q, second: sec6_q};
    end
  end

  assign hms_o = hms_q;

endmodule

FILE: design/e2c_date_calc.sv
// five pipeline stages: day count into year, month and day of month
// depends on e2c_pkg
module e2c_date_calc import e2c_pkg::*; (
  input  logic             clk_i,
  input  logic [4:0]       en_i,
  input  logic [DaysW-1:0] days_i,
  output e2c_date_t        date_o
);

  localparam int unsigned BlkProdW = DaysW + 16;

  logic [DaysW-1:0]    z, zz_d, zz3_q, zz4_q;
  logic [BlkProdW-1:0] blk_prod;
  logic [BlockW-1:0]   blk4_q, blk5_q, blk6_q, blk7_q;
  logic [DaysW-1:0]    blk_days;
  logic [OffW-1:0]     off_d, off5_q;
  logic [YibW-1:0]     yib_d, yib6_q, yib7_q;
  logic [OffW-1:0]     yr_base;
  logic [DoyW-1:0]     doy_d, doy6_q, doy7_q;
  logic [MpW-1:0]      mp_d, mp7_q;
  logic                jan_feb;
  logic [YearW-1:0]    year;
  logic [MonthW-1:0]   month;
  logic [DomW-1:0]     dom;

  function automatic logic [DaysW-1:0] blocks_to_days(input logic [BlockW-1:0] b);
    return DaysW'(b) * DaysW'(DaysPerBlock);
  endfunction

  // days from 1968-03-01, with 2100-02-29 skipped
  assign z    = days_i + EpochOffset;
  assign zz_d = z + DaysW'(z >= CenturySkip);

  assign blk_prod = BlkProdW'(zz3_q) * BlkProdW'(BlockRecip);
  assign blk_days = DaysW'(blocks_to_days(blk4_q));
  assign off_d    = OffW'(zz4_q - blk_days);

  always_comb begin
    if (off5_q >= Year3Start) begin
      yib_d   = 2'd3;
      yr_base = Year3Start;
    end else if (off5_q >= Year2Start) begin
      yib_d   = 2'd2;
      yr_base = Year2Start;
    end else if (off5_q >= Year1Start) begin
      yib_d   = 2'd1;
      yr_base = Year1Start;
    end else begin
      yib_d   = 2'd0;
      yr_base = '0;
    end
    doy_d = DoyW'(off5_q - yr_base);
  end

  // month index counts the month starts at or below the day of year
  always_comb begin
    mp_d = '0;
    for (int i = 1; i < MonthsPerYear; i++) begin
      if (month_start(MpW'(i)) <= doy6_q) begin
        mp_d = mp_d + MpW'(1);
      end
    end
  end

  assign jan_feb = mp7_q >= MpJanuary;
  assign month   = jan_feb ? MonthW'(mp7_q - MpJanuary + MpW'(1)) : MonthW'(mp7_q + MpW'(3));
  assign dom     = DomW'(doy7_q - month_start(mp7_q) + DoyW'(1));
  assign year    = YearBase + YearW'({blk7_q, 2'b00}) + YearW'(yib7_q) + YearW'(jan_feb);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      zz3_q <= zz_d;
    end
    if (en_i[1]) begin
      zz4_q  <= zz3_q;
      blk4_q <= blk_prod[BlockShift +: BlockW];
    end
    if (en_i[2]) begin
      blk5_q <= blk4_q;
      off5_q <= off_d;
    end
    if (en_i[3]) begin
      blk6_q <= blk5_q;
      yib6_q <= yib_d;
      doy6_q <= doy_d;
    end
    if (en_i[4]) begin
      blk7_q <= blk6_q;
      yib7_q <= yib6_q;
      doy7_q <= doy6_q;
      mp7_q  <= mp_d;
    end
  end

  assign date_o = '{year: year, month: month, day: dom};

endmodule

FILE: design/e2c_checker.sv
// port-level checks on the converter and the bind that attaches them
// depends on e2c_pkg and epoch_seconds_to_calendar_defines.svh
`include "epoch_seconds_to_calendar_defines.svh"

module e2c_checker import e2c_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [YearW-1:0]  year_i,
  input logic [MonthW-1:0] month_i,
  input logic [DomW-1:0]   dom_i,
  input logic [HourW-1:0]  hour_i,
  input logic [MinW-1:0]   minute_i,
  input logic [SecW-1:0]   second_i
);

  logic                                         stalled;
  logic [YearW+MonthW+DomW+HourW+MinW+SecW-1:0] payload;
  logic                                         year_ok;
  logic                                         fields_ok;

  assign stalled   = out_valid_i && !out_ready_i;
  assign payload   = {year_i, month_i, dom_i, hour_i, minute_i, second_i};
  assign year_ok   = year_i >= 12'd1970 && year_i <= 12'd2106;
  assign fields_ok = month_i >= 4'd1 && month_i <= 4'd12 && dom_i >= 5'd1
                  && hour_i <= 5'd23 && minute_i <= 6'd59 && second_i <= 6'd59;

  `E2C_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, stalled, out_valid_i, "result dropped while stalled")
  `E2C_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, stalled, $stable(payload), "stalled result changed")
  `E2C_ASSERT_NOW(a_year_range, clk_i, rst_ni, out_valid_i, year_ok, "year out of range")
  `E2C_ASSERT_NOW(a_fields_range, clk_i, rst_ni, out_valid_i, fields_ok, "calendar field out of range")

endmodule

bind epoch_seconds_to_calendar e2c_checker u_e2c_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .year_i      (out_o.year),
  .month_i     (out_o.month),
  .dom_i       (out_o.day_of_month),
  .hour_i      (out_o.hour),
  .minute_i    (out_o.minute),
  .second_i    (out_o.second_of_minute)
);
